@@ rtl/sha1_pkg.sv @@
// Shared types, constants and round functions of the SHA-1 hash engine.
package sha1_pkg;

  localparam int WordW  = 32;
  localparam int LenW   = 64;
  localparam int BlockN = 16;
  localparam int ChainN = 5;
  localparam int RoundW = 7;
  localparam int PosW   = $clog2(BlockN);
  localparam int IdxW   = 3;

  localparam logic [RoundW-1:0] LastRound = RoundW'(79);
  localparam logic [IdxW-1:0]   LastIdx   = IdxW'(ChainN - 1);

  localparam logic [WordW-1:0] PadMark = 32'h8000_0000;

  typedef logic [WordW-1:0] word_t;

  localparam word_t ChainInit [ChainN] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_DIGEST
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push_in;
    logic push_pad;
    logic load_vars;
    logic round_en;
    logic add_chain;
    logic emit;
    logic restart;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_full;
    logic seal;
    logic round_last;
    logic idx_last;
  } status_t;

  // Round constant for round t.
  function automatic word_t sha1_k(input logic [RoundW-1:0] t);
    word_t k;
    if (t < RoundW'(20)) begin
      k = 32'h5A82_7999;
    end else if (t < RoundW'(40)) begin
      k = 32'h6ED9_EBA1;
    end else if (t < RoundW'(60)) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

  // Boolean function of round t.
  function automatic word_t sha1_f(input logic [RoundW-1:0] t, input word_t b,
                                   input word_t c, input word_t d);
    word_t f;
    if (t < RoundW'(20)) begin
      f = (b & c) | (~b & d);
    end else if (t < RoundW'(40)) begin
      f = b ^ c ^ d;
    end else if (t < RoundW'(60)) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

@@ rtl/sha1_stream_if.sv @@
// Valid/ready channel interfaces for message words and digest words.
interface sha1_msg_if;
  logic                          valid;
  logic                          ready;
  logic [sha1_pkg::WordW-1:0]    data_word;
  logic [2:0]                    byte_count;
  logic                          last;

  modport source(output valid, output data_word, output byte_count, output last,
                 input ready);
  modport sink(input valid, input data_word, input byte_count, input last,
               output ready);
endinterface

interface sha1_dig_if;
  logic                          valid;
  logic                          ready;
  logic [sha1_pkg::WordW-1:0]    digest_word;
  logic [sha1_pkg::IdxW-1:0]     word_index;
  logic                          last_word;

  modport source(output valid, output digest_word, output word_index,
                 output last_word, input ready);
  modport sink(input valid, input digest_word, input word_index, input last_word,
               output ready);
endinterface

@@ rtl/sha1_ctrl.sv @@
// Controller state machine of the SHA-1 hash engine.
module sha1_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sha1_pkg::status_t status,
  output sha1_pkg::cmd_t    cmd
);
  import sha1_pkg::*;

  state_t state, state_next;
  logic   tail, tail_next;
  logic   sealed, sealed_next;

  // State and padding flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      tail   <= 1'b0;
      sealed <= 1'b0;
    end else begin
      state  <= state_next;
      tail   <= tail_next;
      sealed <= sealed_next;
    end
  end

  // Next state.
  always_comb begin
    state_next  = state;
    tail_next   = tail;
    sealed_next = sealed;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.pos_full) begin
            state_next = S_ROUND;
            tail_next  = in_last;
          end else if (in_last) begin
            state_next = S_PAD;
            tail_next  = 1'b1;
          end
        end
      end
      S_PAD: begin
        if (status.pos_full) begin
          state_next  = S_ROUND;
          sealed_next = status.seal;
        end
      end
      S_ROUND: begin
        if (status.round_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (sealed) begin
          state_next = S_DIGEST;
        end else if (tail) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIGEST: begin
        if (out_ready && status.idx_last) begin
          state_next  = S_IDLE;
          tail_next   = 1'b0;
          sealed_next = 1'b0;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath commands and handshake outputs.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.push_in   = in_valid;
        cmd.load_vars = in_valid && status.pos_full;
      end
      S_PAD: begin
        cmd.push_pad  = 1'b1;
        cmd.load_vars = status.pos_full;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
      end
      S_DIGEST: begin
        out_valid   = 1'b1;
        cmd.emit    = out_ready;
        cmd.restart = out_ready && status.idx_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/sha1_datapath.sv @@
// Datapath of the SHA-1 hash engine: message schedule, rounds, chaining words.
module sha1_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  sha1_pkg::cmd_t             cmd,
  output sha1_pkg::status_t          status,
  input  logic [sha1_pkg::WordW-1:0] data_word,
  input  logic [2:0]                 byte_count,
  input  logic                       last,
  output logic [sha1_pkg::WordW-1:0] digest_word,
  output logic [sha1_pkg::IdxW-1:0]  word_index,
  output logic                       last_word
);
  import sha1_pkg::*;

  // Schedule window: entry 0 holds the oldest word.
  word_t sched [BlockN];
  word_t vars  [ChainN];
  word_t chain [ChainN];

  logic [LenW-1:0]   bit_length;
  logic [PosW-1:0]   word_position;
  logic [RoundW-1:0] round_counter;
  logic [IdxW-1:0]   idx;
  logic              mark_pend;
  logic              hi_done;

  logic [2:0]  count_eff;
  logic        full_word;
  word_t       keep;
  word_t       tail_word;
  word_t       in_word;
  word_t       pad_word;
  word_t       push_word;
  logic        push;
  logic        pad_hi;
  logic        pad_lo;
  word_t       w_mix;
  word_t       w_t;
  word_t       round_sum;

  // Tail word: keep the valid bytes and place the pad mark after them.
  always_comb begin
    count_eff = (byte_count > 3'd4) ? 3'd4 : byte_count;
    full_word = !last || (count_eff == 3'd4);
    case (count_eff)
      3'd0:    keep = 32'h0000_0000;
      3'd1:    keep = 32'hFF00_0000;
      3'd2:    keep = 32'hFFFF_0000;
      3'd3:    keep = 32'hFFFF_FF00;
      default: keep = 32'hFFFF_FFFF;
    endcase
    tail_word = (data_word & keep) | (PadMark >> {count_eff, 3'b000});
    in_word   = full_word ? data_word : tail_word;
  end

  // Padding words: deferred mark, zero fill, then the bit length.
  always_comb begin
    pad_hi = !mark_pend && !hi_done && (word_position == PosW'(BlockN - 2));
    pad_lo = !mark_pend && hi_done && (word_position == PosW'(BlockN - 1));
    if (mark_pend) begin
      pad_word = PadMark;
    end else if (pad_hi) begin
      pad_word = bit_length[LenW-1:WordW];
    end else if (pad_lo) begin
      pad_word = bit_length[WordW-1:0];
    end else begin
      pad_word = '0;
    end
    push      = cmd.push_in || cmd.push_pad;
    push_word = cmd.push_in ? in_word : pad_word;
  end

  // One round: schedule word and compression step.
  always_comb begin
    w_mix     = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
    w_t       = (round_counter < RoundW'(BlockN)) ? sched[0]
                                                   : {w_mix[WordW-2:0], w_mix[WordW-1]};
    round_sum = {vars[0][WordW-6:0], vars[0][WordW-1:WordW-5]}
              + sha1_f(round_counter, vars[1], vars[2], vars[3])
              + vars[4] + w_t + sha1_k(round_counter);
  end

  // Control state and chaining words.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < ChainN; i++) begin
        chain[i] <= ChainInit[i];
      end
      bit_length    <= '0;
      word_position <= '0;
      round_counter <= '0;
      idx           <= '0;
      mark_pend     <= 1'b0;
      hi_done       <= 1'b0;
    end else begin
      if (push) begin
        word_position <= word_position + PosW'(1);
      end
      if (cmd.push_in) begin
        bit_length <= bit_length + (last ? LenW'({count_eff, 3'b000}) : LenW'(WordW));
        mark_pend  <= last && (count_eff == 3'd4);
      end
      if (cmd.push_pad) begin
        if (mark_pend) begin
          mark_pend <= 1'b0;
        end else if (pad_hi) begin
          hi_done <= 1'b1;
        end
      end
      round_counter <= cmd.round_en ? round_counter + RoundW'(1) : '0;
      if (cmd.add_chain) begin
        for (int i = 0; i < ChainN; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      if (cmd.emit) begin
        idx <= idx + IdxW'(1);
      end
    end
  end

  // Schedule window and working variables.
  always_ff @(posedge clk) begin
    if (push || cmd.round_en) begin
      for (int i = 0; i < BlockN - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[BlockN-1] <= push ? push_word : w_t;
    end
    if (cmd.load_vars) begin
      for (int i = 0; i < ChainN; i++) begin
        vars[i] <= chain[i];
      end
    end else if (cmd.round_en) begin
      vars[4] <= vars[3];
      vars[3] <= vars[2];
      vars[2] <= {vars[1][1:0], vars[1][WordW-1:2]};
      vars[1] <= vars[0];
      vars[0] <= round_sum;
    end
  end

  // Status and digest outputs.
  always_comb begin
    status.pos_full   = (word_position == PosW'(BlockN - 1));
    status.seal       = cmd.push_pad && pad_lo;
    status.round_last = (round_counter == LastRound);
    status.idx_last   = (idx == LastIdx);
    digest_word       = chain[idx];
    word_index        = idx;
    last_word         = (idx == LastIdx);
  end

endmodule

@@ rtl/sha1_hash_engine_top.sv @@
// SHA-1 hash engine: message words in on msg, five digest words out on dig.
// Usage: stream a message on msg as 32-bit words, first byte in bits 31:24.
// Every request but the last carries four bytes; the request with last set
// carries byte_count bytes (0 to 4, larger counts read as 4) and closes the
// message. The engine pads it, hashes the final blocks and then offers the
// digest on dig as five requests, H0 to H4, with word_index 0 to 4 and
// last_word set on H4.
// Timing: a word is taken whenever msg is ready; the sixteenth word of a block
// starts the 80 SHA-1 rounds and one chaining add, during which msg is not ready.
// The round unit runs one SHA-1 round per cycle. After the last word, padding
// fills the block up to its end, and one or two compressions run before the
// first digest word appears.
// Stalls: digest words wait in place while dig.ready is low; no new message
// word is taken until H4 has been taken. Then the engine restarts for a new
// message. Reset (synchronous, active high) drops any message in progress,
// reloads the initial chaining words and leaves msg ready.
module sha1_hash_engine_top (
  input logic        clk,
  input logic        rst,
  sha1_msg_if.sink   msg,
  sha1_dig_if.source dig
);
  import sha1_pkg::*;

  cmd_t    cmd;
  status_t status;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg.valid),
    .in_last   (msg.last),
    .in_ready  (msg.ready),
    .out_valid (dig.valid),
    .out_ready (dig.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sha1_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_word   (msg.data_word),
    .byte_count  (msg.byte_count),
    .last        (msg.last),
    .digest_word (dig.digest_word),
    .word_index  (dig.word_index),
    .last_word   (dig.last_word)
  );

endmodule
